/* hdl/pts_pkg.sv */
// Shared types, widths and codes for the preemptive tick scheduler.
// Used by the controller, the datapath, the remainder unit and the top level.
// No dependencies.
`default_nettype none

package pts_pkg;

    localparam int TIME_W      = 64;
    localparam int QUANT_W     = 32;
    localparam int LIMIT_W     = 16;
    localparam int TCOUNT_W    = 4;
    localparam int CNT_W       = 32;
    localparam int SEL_W       = 4;
    localparam int OP_W        = 2;
    localparam int NEXT_TASK_W = 3;

    localparam int TASKS_MAX = 8;
    localparam int TASK_W    = (TASKS_MAX > 1) ? $clog2(TASKS_MAX) : 1;
    localparam int MOD_W     = $clog2(TASKS_MAX + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int S_FIELDS_W = 6 * TIME_W + SEL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = NEXT_TASK_W + 1 + 2 * TIME_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [QUANT_W-1:0]  QUANTUM_RST    = QUANT_W'(10000);
    localparam logic [LIMIT_W-1:0]  TICK_LIMIT_RST = LIMIT_W'(200);
    localparam logic [TCOUNT_W-1:0] TASK_COUNT_RST = TCOUNT_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_FINAL = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUANTUM    = 2'd0,
        CFG_TICK_LIMIT = 2'd1,
        CFG_TASK_COUNT = 2'd2
    } cfg_idx_t;

    typedef enum logic [SEL_W-1:0] {
        SEL_LAT_MIN  = 4'd0,
        SEL_LAT_MAX  = 4'd1,
        SEL_LAT_SUM  = 4'd2,
        SEL_CYC_MIN  = 4'd3,
        SEL_CYC_MAX  = 4'd4,
        SEL_CYC_SUM  = 4'd5,
        SEL_TIM_MIN  = 4'd6,
        SEL_TIM_MAX  = 4'd7,
        SEL_TIM_SUM  = 4'd8,
        SEL_SWITCHES = 4'd9,
        SEL_TICKS    = 4'd10
    } sel_t;

    typedef struct packed {
        logic load;
        logic start_clr;
        logic fold_lat;
        logic fold_cyc;
        logic fold_tim;
        logic tick_upd;
        logic arm_sum;
        logic arm_first;
        logic arm_d;
        logic div_start;
        logic arm_fin;
        logic read_stat;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic q_zero;
        logic d_above;
        logic rem_done;
        logic prev_valid;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

/* hdl/pts_rem.sv */
// Iterative remainder unit: 64-bit dividend by 32-bit divisor, two bits a cycle.
// Depends on pts_pkg.
`default_nettype none

module pts_rem (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [pts_pkg::TIME_W-1:0]    dividend,
    input  wire logic [pts_pkg::QUANT_W-1:0]   divisor,
    output logic                               done,
    output logic      [pts_pkg::QUANT_W-1:0]   rem
);
    import pts_pkg::*;

    localparam int ITER  = TIME_W / 2;
    localparam int ITR_W = $clog2(ITER);

    logic [TIME_W-1:0]  dvd_reg, dvd_next;
    logic [QUANT_W-1:0] rem_reg, rem_next;
    logic [ITR_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [QUANT_W-1:0] step1, step2;

    function automatic logic [QUANT_W-1:0] rem_step(input logic [QUANT_W-1:0] r,
                                                    input logic b,
                                                    input logic [QUANT_W-1:0] d);
        logic [QUANT_W:0] t;
        t = {r, b};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[QUANT_W-1:0];
    endfunction

    always_comb begin
        step1     = rem_step(rem_reg, dvd_reg[TIME_W-1], divisor);
        step2     = rem_step(step1, dvd_reg[TIME_W-2], divisor);
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[TIME_W-3:0], 2'b00};
            rem_next = step2;
            cnt_next = cnt_reg + ITR_W'(1);
            if (cnt_reg == ITR_W'(ITER - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

/* hdl/pts_dp.sv */
// Datapath of the tick scheduler: configuration, statistics, deadline and result registers.
// Depends on pts_pkg and pts_rem; driven by commands from pts_ctrl.
`default_nettype none

module pts_dp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic [pts_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire pts_pkg::cmd_t                   cmd,
    output pts_pkg::sts_t                        sts,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [pts_pkg::M_TDATA_W-1:0]   m_tdata
);
    import pts_pkg::*;

    logic [QUANT_W-1:0]  quantum_reg, quantum_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [TCOUNT_W-1:0] tcount_reg, tcount_next;

    logic [TIME_W-1:0] em_reg, em_next;
    logic [TIME_W-1:0] ec_reg, ec_next;
    logic [TIME_W-1:0] xm_reg, xm_next;
    logic [TIME_W-1:0] xc_reg, xc_next;
    logic [TIME_W-1:0] first_reg, first_next;
    logic [TIME_W-1:0] second_reg, second_next;
    logic [SEL_W-1:0]  sel_reg, sel_next;

    logic [CNT_W-1:0]  tick_reg, tick_next;
    logic [TASK_W-1:0] task_reg, task_next;
    logic              none_reg, none_next;
    logic [TIME_W-1:0] deadline_reg, deadline_next;
    logic              prev_reg, prev_next;
    logic [TIME_W-1:0] sav_cyc_reg, sav_cyc_next;
    logic [TIME_W-1:0] sav_mt_reg, sav_mt_next;
    logic [TIME_W-1:0] lat_min_reg, lat_min_next, lat_max_reg, lat_max_next;
    logic [TIME_W-1:0] lat_sum_reg, lat_sum_next;
    logic [TIME_W-1:0] cyc_min_reg, cyc_min_next, cyc_max_reg, cyc_max_next;
    logic [TIME_W-1:0] cyc_sum_reg, cyc_sum_next;
    logic [TIME_W-1:0] tim_min_reg, tim_min_next, tim_max_reg, tim_max_next;
    logic [TIME_W-1:0] tim_sum_reg, tim_sum_next;
    logic [CNT_W-1:0]  sw_reg, sw_next;
    logic [TIME_W-1:0] armd_reg, armd_next;

    logic [NEXT_TASK_W-1:0] res_task_reg, res_task_next;
    logic                   res_boot_reg, res_boot_next;
    logic [TIME_W-1:0]      res_stat_reg, res_stat_next;
    logic [M_TDATA_W-1:0]   out_reg, out_next;
    logic                   mvalid_reg, mvalid_next;

    logic [TIME_W-1:0]  lat_val, cyc_val, tim_val;
    logic [CNT_W-1:0]   tick_inc;
    logic [MOD_W-1:0]   n_tasks;
    logic [TIME_W-1:0]  div_dvd;
    logic [QUANT_W-1:0] rem_val;
    logic               rem_done;

    function automatic logic [MOD_W-1:0] small_mod(input logic [MOD_W-1:0] v,
                                                   input logic [MOD_W-1:0] n);
        logic [MOD_W-1:0] r;
        r = v;
        for (int i = 0; i < TASKS_MAX; i++) begin
            if (r >= n) begin
                r = r - n;
            end
        end
        return r;
    endfunction

    pts_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (quantum_reg),
        .done     (rem_done),
        .rem      (rem_val)
    );

    assign lat_val  = em_reg - deadline_reg;
    assign cyc_val  = xc_reg - sav_cyc_reg;
    assign tim_val  = xm_reg - sav_mt_reg;
    assign tick_inc = tick_reg + CNT_W'(1);
    assign div_dvd  = second_reg - armd_reg;

    always_comb begin
        if (tcount_reg == '0) begin
            n_tasks = MOD_W'(1);
        end else if (int'(tcount_reg) > TASKS_MAX) begin
            n_tasks = MOD_W'(TASKS_MAX);
        end else begin
            n_tasks = MOD_W'(tcount_reg);
        end
    end

    always_comb begin
        quantum_next  = quantum_reg;
        limit_next    = limit_reg;
        tcount_next   = tcount_reg;
        em_next       = em_reg;
        ec_next       = ec_reg;
        xm_next       = xm_reg;
        xc_next       = xc_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        sel_next      = sel_reg;
        tick_next     = tick_reg;
        task_next     = task_reg;
        none_next     = none_reg;
        deadline_next = deadline_reg;
        prev_next     = prev_reg;
        sav_cyc_next  = sav_cyc_reg;
        sav_mt_next   = sav_mt_reg;
        lat_min_next  = lat_min_reg;
        lat_max_next  = lat_max_reg;
        lat_sum_next  = lat_sum_reg;
        cyc_min_next  = cyc_min_reg;
        cyc_max_next  = cyc_max_reg;
        cyc_sum_next  = cyc_sum_reg;
        tim_min_next  = tim_min_reg;
        tim_max_next  = tim_max_reg;
        tim_sum_next  = tim_sum_reg;
        sw_next       = sw_reg;
        armd_next     = armd_reg;
        res_task_next = res_task_reg;
        res_boot_next = res_boot_reg;
        res_stat_next = res_stat_reg;
        out_next      = out_reg;
        mvalid_next   = mvalid_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_QUANTUM:    quantum_next = cfg_wdata[QUANT_W-1:0];
                CFG_TICK_LIMIT: limit_next   = cfg_wdata[LIMIT_W-1:0];
                CFG_TASK_COUNT: tcount_next  = cfg_wdata[TCOUNT_W-1:0];
                default: ;
            endcase
        end

        if (cmd.load) begin
            em_next       = s_tdata[0*TIME_W +: TIME_W];
            ec_next       = s_tdata[1*TIME_W +: TIME_W];
            xm_next       = s_tdata[2*TIME_W +: TIME_W];
            xc_next       = s_tdata[3*TIME_W +: TIME_W];
            first_next    = s_tdata[4*TIME_W +: TIME_W];
            second_next   = s_tdata[5*TIME_W +: TIME_W];
            sel_next      = s_tdata[6*TIME_W +: SEL_W];
            res_task_next = '0;
            res_boot_next = 1'b0;
            res_stat_next = '0;
        end

        if (cmd.start_clr) begin
            tick_next = '0;
            prev_next = 1'b0;
        end

        if (cmd.fold_lat) begin
            if (lat_val < lat_min_reg) begin
                lat_min_next = lat_val;
            end
            if (lat_val > lat_max_reg) begin
                lat_max_next = lat_val;
            end
            lat_sum_next = lat_sum_reg + lat_val;
        end

        if (cmd.fold_cyc) begin
            if (cyc_val < cyc_min_reg) begin
                cyc_min_next = cyc_val;
            end
            if (cyc_val > cyc_max_reg) begin
                cyc_max_next = cyc_val;
            end
            cyc_sum_next = cyc_sum_reg + cyc_val;
        end

        if (cmd.fold_tim) begin
            if (tim_val < tim_min_reg) begin
                tim_min_next = tim_val;
            end
            if (tim_val > tim_max_reg) begin
                tim_max_next = tim_val;
            end
            tim_sum_next = tim_sum_reg + tim_val;
            sw_next      = sw_reg + CNT_W'(1);
        end

        if (cmd.tick_upd) begin
            tick_next = tick_inc;
            if (tick_inc >= CNT_W'(limit_reg)) begin
                res_boot_next = 1'b1;
            end else if (none_reg) begin
                none_next     = 1'b0;
                task_next     = '0;
                res_task_next = '0;
            end else begin
                task_next     = TASK_W'(small_mod(MOD_W'(task_reg) + MOD_W'(1), n_tasks));
                res_task_next = NEXT_TASK_W'(task_next);
            end
            sav_cyc_next = ec_reg;
            sav_mt_next  = em_reg;
            prev_next    = 1'b1;
        end

        if (cmd.arm_sum) begin
            armd_next = first_reg + TIME_W'(quantum_reg);
        end
        if (cmd.arm_first) begin
            deadline_next = first_reg;
        end
        if (cmd.arm_d) begin
            deadline_next = armd_reg;
        end
        if (cmd.arm_fin) begin
            deadline_next = second_reg + TIME_W'(quantum_reg - rem_val);
        end

        if (cmd.read_stat) begin
            unique case (sel_reg)
                SEL_LAT_MIN:  res_stat_next = lat_min_reg;
                SEL_LAT_MAX:  res_stat_next = lat_max_reg;
                SEL_LAT_SUM:  res_stat_next = lat_sum_reg;
                SEL_CYC_MIN:  res_stat_next = cyc_min_reg;
                SEL_CYC_MAX:  res_stat_next = cyc_max_reg;
                SEL_CYC_SUM:  res_stat_next = cyc_sum_reg;
                SEL_TIM_MIN:  res_stat_next = tim_min_reg;
                SEL_TIM_MAX:  res_stat_next = tim_max_reg;
                SEL_TIM_SUM:  res_stat_next = tim_sum_reg;
                SEL_SWITCHES: res_stat_next = TIME_W'(sw_reg);
                SEL_TICKS:    res_stat_next = TIME_W'(tick_reg);
                default:      res_stat_next = '0;
            endcase
        end

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        if (cmd.out_load) begin
            out_next    = M_TDATA_W'({res_stat_reg, deadline_reg, res_boot_reg, res_task_reg});
            mvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg  <= QUANTUM_RST;
            limit_reg    <= TICK_LIMIT_RST;
            tcount_reg   <= TASK_COUNT_RST;
            tick_reg     <= '0;
            task_reg     <= '0;
            none_reg     <= 1'b1;
            deadline_reg <= '0;
            prev_reg     <= 1'b0;
            sav_cyc_reg  <= '0;
            sav_mt_reg   <= '0;
            lat_min_reg  <= '1;
            lat_max_reg  <= '0;
            lat_sum_reg  <= '0;
            cyc_min_reg  <= '1;
            cyc_max_reg  <= '0;
            cyc_sum_reg  <= '0;
            tim_min_reg  <= '1;
            tim_max_reg  <= '0;
            tim_sum_reg  <= '0;
            sw_reg       <= '0;
            mvalid_reg   <= 1'b0;
        end else begin
            quantum_reg  <= quantum_next;
            limit_reg    <= limit_next;
            tcount_reg   <= tcount_next;
            tick_reg     <= tick_next;
            task_reg     <= task_next;
            none_reg     <= none_next;
            deadline_reg <= deadline_next;
            prev_reg     <= prev_next;
            sav_cyc_reg  <= sav_cyc_next;
            sav_mt_reg   <= sav_mt_next;
            lat_min_reg  <= lat_min_next;
            lat_max_reg  <= lat_max_next;
            lat_sum_reg  <= lat_sum_next;
            cyc_min_reg  <= cyc_min_next;
            cyc_max_reg  <= cyc_max_next;
            cyc_sum_reg  <= cyc_sum_next;
            tim_min_reg  <= tim_min_next;
            tim_max_reg  <= tim_max_next;
            tim_sum_reg  <= tim_sum_next;
            sw_reg       <= sw_next;
            mvalid_reg   <= mvalid_next;
        end
        em_reg       <= em_next;
        ec_reg       <= ec_next;
        xm_reg       <= xm_next;
        xc_reg       <= xc_next;
        first_reg    <= first_next;
        second_reg   <= second_next;
        sel_reg      <= sel_next;
        armd_reg     <= armd_next;
        res_task_reg <= res_task_next;
        res_boot_reg <= res_boot_next;
        res_stat_reg <= res_stat_next;
        out_reg      <= out_next;
    end

    assign sts.q_zero     = (quantum_reg == '0);
    assign sts.d_above    = (armd_reg > second_reg);
    assign sts.rem_done   = rem_done;
    assign sts.prev_valid = prev_reg;
    assign sts.out_free   = !mvalid_reg || m_tready;

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire

/* hdl/pts_ctrl.sv */
// Controller state machine of the tick scheduler: sequences one event through the datapath.
// Depends on pts_pkg; talks to pts_dp through the command and status structs.
`default_nettype none

module pts_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [pts_pkg::OP_W-1:0]  s_tuser,
    input  wire pts_pkg::sts_t             sts,
    output pts_pkg::cmd_t                  cmd
);
    import pts_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_START   = 12'b0000_0000_0010,
        S_LAT     = 12'b0000_0000_0100,
        S_CYC     = 12'b0000_0000_1000,
        S_TIM     = 12'b0000_0001_0000,
        S_TICK    = 12'b0000_0010_0000,
        S_ARM_SUM = 12'b0000_0100_0000,
        S_ARM_CHK = 12'b0000_1000_0000,
        S_DIV     = 12'b0001_0000_0000,
        S_ARM_FIN = 12'b0010_0000_0000,
        S_READ    = 12'b0100_0000_0000,
        S_DONE    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    op_next  = op_t'(s_tuser);
                    unique case (op_t'(s_tuser))
                        OP_START: state_next = S_START;
                        OP_TICK:  state_next = S_LAT;
                        OP_FINAL: state_next = S_CYC;
                        OP_READ:  state_next = S_READ;
                    endcase
                end
            end
            S_START: begin
                cmd.start_clr = 1'b1;
                state_next    = S_ARM_SUM;
            end
            S_LAT: begin
                cmd.fold_lat = 1'b1;
                state_next   = sts.prev_valid ? S_CYC : S_TICK;
            end
            S_CYC: begin
                cmd.fold_cyc = 1'b1;
                state_next   = S_TIM;
            end
            S_TIM: begin
                cmd.fold_tim = 1'b1;
                state_next   = (op_reg == OP_TICK) ? S_TICK : S_DONE;
            end
            S_TICK: begin
                cmd.tick_upd = 1'b1;
                state_next   = S_ARM_SUM;
            end
            S_ARM_SUM: begin
                cmd.arm_sum = 1'b1;
                state_next  = S_ARM_CHK;
            end
            S_ARM_CHK: begin
                priority if (sts.q_zero) begin
                    cmd.arm_first = 1'b1;
                    state_next    = S_DONE;
                end else if (sts.d_above) begin
                    cmd.arm_d  = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (sts.rem_done) begin
                    state_next = S_ARM_FIN;
                end
            end
            S_ARM_FIN: begin
                cmd.arm_fin = 1'b1;
                state_next  = S_DONE;
            end
            S_READ: begin
                cmd.read_stat = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_START;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

/* hdl/preemptive_tick_scheduler_with_stats.sv */
// Top level of the preemptive round-robin tick scheduler with timing statistics.
// Depends on pts_pkg, pts_ctrl, pts_dp and pts_rem.
//
// The block takes one event at a time and returns exactly one result transfer
// per event. A read event goes through the read and done states, and a final
// event through the cycle fold, time fold and done states. For a start or tick
// event the result comes sooner when the quantum is zero or the first deadline
// plus one quantum already lies beyond the second timer reading, and later when
// the deadline must be moved forward by whole quanta. The longer path runs the
// remainder unit, which retires two dividend bits a cycle over 64 bits.
// The next input transfer can be taken from the cycle in which the result is
// presented. A finished result waits in the output register while the next
// event is already being taken. Configuration writes take effect at once and
// are meant for idle periods only.
`default_nettype none

module preemptive_tick_scheduler_with_stats (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // entry_mtime, entry_cycles, exit_mtime, exit_cycles, arm_time_first,
    // arm_time_second, stat_select, zero padding
    input  wire logic [pts_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode
    input  wire logic [pts_pkg::OP_W-1:0]        s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // next_task, to_boot, new_deadline, stat_value, zero padding
    output logic      [pts_pkg::M_TDATA_W-1:0]   m_tdata
);
    import pts_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    pts_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for preemptive_tick_scheduler_with_stats: directed corner events, then
// shaped random timer traffic under several register settings and a stalled result sink,
// with an in-bench scheduler prediction. Needs only pts_pkg and the scheduler RTL.

module tb;

    import pts_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 50;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 128;
    localparam int REPORT_MAX     = 10;

    localparam logic [TCOUNT_W-1:0] TASK_NONE  = 4'hF;
    localparam logic [SEL_W-1:0]    SEL_UNUSED = 4'd11;

    localparam int STAT_LATENCY = 0;
    localparam int STAT_CYCLES  = 1;
    localparam int STAT_MTIME   = 2;

    localparam int BOOT_BIT = NEXT_TASK_W;
    localparam int DL_LSB   = NEXT_TASK_W + 1;
    localparam int SV_LSB   = DL_LSB + TIME_W;

    typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    typedef struct packed {
        op_t               op;
        logic [SEL_W-1:0]  stat_select;
        logic [TIME_W-1:0] entry_mtime, entry_cycles, exit_mtime, exit_cycles;
        logic [TIME_W-1:0] arm_first, arm_second;
    } timer_event_t;

    typedef struct packed {
        logic [NEXT_TASK_W-1:0] next_task;
        logic                   to_boot;
        logic [TIME_W-1:0]      new_deadline;
        logic [TIME_W-1:0]      stat_value;
    } sched_outcome_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // Scheduler state as predicted by the bench.
    logic [QUANT_W-1:0]  slice_len      = QUANTUM_RST;
    logic [LIMIT_W-1:0]  boot_limit     = TICK_LIMIT_RST;
    logic [TCOUNT_W-1:0] rotation_size  = TASK_COUNT_RST;
    logic [CNT_W-1:0]    ticks_seen     = '0;
    logic [CNT_W-1:0]    switch_total   = '0;
    logic [TCOUNT_W-1:0] cur_task       = TASK_NONE;
    logic [TIME_W-1:0]   deadline       = '0;
    logic                switch_pending = 1'b0;
    logic [TIME_W-1:0]   last_entry_cycles = '0;
    logic [TIME_W-1:0]   last_entry_mtime  = '0;
    logic [TIME_W-1:0]   stat_min [0:2];
    logic [TIME_W-1:0]   stat_max [0:2];
    logic [TIME_W-1:0]   stat_sum [0:2];

    // Notional platform clocks from which well-formed events are drawn.
    logic [TIME_W-1:0] clock_mtime  = 64'd5000;
    logic [TIME_W-1:0] clock_cycles = 64'd100000;

    sched_outcome_t outcomes_due[$];
    int mismatch_count = 0;
    int items_sent     = 0;
    int burst_left     = 0;
    bit gapless        = 1'b0;
    int hold_off_req   = 0;

    preemptive_tick_scheduler_with_stats DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void fold_stat(input int kind, input logic [TIME_W-1:0] v);
        if (v < stat_min[kind]) stat_min[kind] = v;
        if (v > stat_max[kind]) stat_max[kind] = v;
        stat_sum[kind] = stat_sum[kind] + v;
    endfunction

    function automatic void fold_switch(input logic [TIME_W-1:0] ex_cycles,
                                        input logic [TIME_W-1:0] ex_mtime);
        fold_stat(STAT_CYCLES, ex_cycles - last_entry_cycles);
        fold_stat(STAT_MTIME, ex_mtime - last_entry_mtime);
        switch_total = switch_total + 32'd1;
    endfunction

    function automatic logic [TIME_W-1:0] arm_deadline(input logic [TIME_W-1:0] base,
                                                       input logic [TIME_W-1:0] floor_t);
        logic [TIME_W-1:0] step, d, k;
        step = {32'd0, slice_len};
        if (step == '0) return base;
        d = base + step;
        if (d <= floor_t) begin
            k = (floor_t - d) / step + 64'd1;
            d = d + k * step;
        end
        return d;
    endfunction

    function automatic sched_outcome_t scheduler_outcome(input timer_event_t ev);
        sched_outcome_t r;
        int n, idx;
        r = '0;
        case (ev.op)
            OP_START: begin
                ticks_seen = '0;
                switch_pending = 1'b0;
                deadline = arm_deadline(ev.arm_first, ev.arm_second);
            end
            OP_TICK: begin
                ticks_seen = ticks_seen + 32'd1;
                fold_stat(STAT_LATENCY, ev.entry_mtime - deadline);
                if (switch_pending) fold_switch(ev.exit_cycles, ev.exit_mtime);
                deadline = arm_deadline(ev.arm_first, ev.arm_second);
                if (ticks_seen >= {16'd0, boot_limit}) begin
                    r.to_boot = 1'b1;
                end else begin
                    n = int'(rotation_size);
                    if (n == 0) n = 1;
                    if (n > TASKS_MAX) n = TASKS_MAX;
                    idx = (cur_task == TASK_NONE) ? 0 : (int'(cur_task) + 1) % n;
                    cur_task = 4'(idx);
                    r.next_task = 3'(idx);
                end
                last_entry_cycles = ev.entry_cycles;
                last_entry_mtime = ev.entry_mtime;
                switch_pending = 1'b1;
            end
            OP_FINAL: begin
                fold_switch(ev.exit_cycles, ev.exit_mtime);
            end
            default: begin
                case (ev.stat_select)
                    SEL_LAT_MIN:  r.stat_value = stat_min[STAT_LATENCY];
                    SEL_LAT_MAX:  r.stat_value = stat_max[STAT_LATENCY];
                    SEL_LAT_SUM:  r.stat_value = stat_sum[STAT_LATENCY];
                    SEL_CYC_MIN:  r.stat_value = stat_min[STAT_CYCLES];
                    SEL_CYC_MAX:  r.stat_value = stat_max[STAT_CYCLES];
                    SEL_CYC_SUM:  r.stat_value = stat_sum[STAT_CYCLES];
                    SEL_TIM_MIN:  r.stat_value = stat_min[STAT_MTIME];
                    SEL_TIM_MAX:  r.stat_value = stat_max[STAT_MTIME];
                    SEL_TIM_SUM:  r.stat_value = stat_sum[STAT_MTIME];
                    SEL_SWITCHES: r.stat_value = {32'd0, switch_total};
                    SEL_TICKS:    r.stat_value = {32'd0, ticks_seen};
                    default:      r.stat_value = '0;
                endcase
            end
        endcase
        r.new_deadline = deadline;
        return r;
    endfunction

    // A plausible event: entries other than a start land near the armed deadline, exits follow the last entry.
    function automatic timer_event_t shaped_event(input op_t op);
        timer_event_t ev;
        int pick;
        ev.op = op;
        ev.stat_select = 4'($urandom_range(0, 10));
        if (op == OP_START) begin
            ev.entry_mtime = clock_mtime;
        end else if ($urandom_range(0, 9) == 0) begin
            ev.entry_mtime = deadline - 64'($urandom_range(1, 100));
        end else begin
            ev.entry_mtime = deadline + 64'($urandom_range(0, 400));
        end
        ev.entry_cycles = clock_cycles + 64'($urandom_range(100, 5000));
        ev.exit_mtime = last_entry_mtime + 64'($urandom_range(30, 900));
        ev.exit_cycles = last_entry_cycles + 64'($urandom_range(200, 9000));
        ev.arm_first = ev.entry_mtime + 64'($urandom_range(10, 300));
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            ev.arm_second = ev.arm_first + 64'($urandom_range(0, 500));
        end else if (pick < 9) begin
            ev.arm_second = ev.arm_first + {32'd0, $urandom} * 64'($urandom_range(1, 3));
        end else begin
            ev.arm_second = rand64();
        end
        clock_mtime = ev.arm_first;
        clock_cycles = ev.entry_cycles;
        return ev;
    endfunction

    function automatic timer_event_t noise_event();
        timer_event_t ev;
        ev.op = op_t'($urandom_range(0, 3));
        ev.stat_select = 4'($urandom_range(0, 15));
        ev.entry_mtime = rand64();
        ev.entry_cycles = rand64();
        ev.exit_mtime = rand64();
        ev.exit_cycles = rand64();
        ev.arm_first = rand64();
        ev.arm_second = rand64();
        return ev;
    endfunction

    task automatic send_event(input timer_event_t ev);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[S_FIELDS_W-1:0] = {ev.stat_select, ev.arm_second, ev.arm_first, ev.exit_cycles,
                                ev.exit_mtime, ev.entry_cycles, ev.entry_mtime};
        s_tdata <= word;
        s_tuser <= ev.op;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        outcomes_due.push_back(scheduler_outcome(ev));
        items_sent++;
        if (!gapless) begin
            if (burst_left <= 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_QUANTUM:    slice_len = value;
            CFG_TICK_LIMIT: boot_limit = value[LIMIT_W-1:0];
            CFG_TASK_COUNT: rotation_size = value[TCOUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] q, input logic [31:0] lim,
                              input logic [31:0] cnt);
        settle();
        write_reg(CFG_QUANTUM, q);
        write_reg(CFG_TICK_LIMIT, lim);
        write_reg(CFG_TASK_COUNT, cnt);
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        sched_outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (outcomes_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: result transfer with nothing expected: %h", $time, m_tdata);
            end else begin
                want = outcomes_due.pop_front();
                check_field("next_task", 64'(want.next_task), 64'(m_tdata[NEXT_TASK_W-1:0]));
                check_field("to_boot", 64'(want.to_boot), 64'(m_tdata[BOOT_BIT]));
                check_field("new_deadline", want.new_deadline, m_tdata[DL_LSB +: TIME_W]);
                check_field("stat_value", want.stat_value, m_tdata[SV_LSB +: TIME_W]);
            end
        end
    end

    initial begin : result_sink
        rx_mode_t mode;
        int left, hold;
        mode = RX_OPEN;
        left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req != 0) begin
                hold = hold_off_req;
                hold_off_req = 0;
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            if (left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
                RX_OPEN:     m_tready <= 1'b1;
                RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: m_tready <= (left % 7 < 3);
                default:     m_tready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic test_reset_values();
        timer_event_t ev;
        ev = noise_event();
        ev.op = OP_READ;
        ev.stat_select = SEL_LAT_MIN;
        send_event(ev);
        ev.stat_select = SEL_TICKS;
        send_event(ev);
        // A final switch with no tick before it measures from the cleared entry stamps.
        ev.op = OP_FINAL;
        ev.exit_cycles = '1;
        ev.exit_mtime = 64'd123;
        send_event(ev);
        ev.op = OP_READ;
        ev.stat_select = SEL_CYC_MAX;
        send_event(ev);
        ev.stat_select = SEL_UNUSED;
        send_event(ev);
    endtask

    task automatic test_arming();
        timer_event_t ev;
        ev = shaped_event(OP_START);
        ev.arm_first = 64'd1000;
        ev.arm_second = 64'd500;
        send_event(ev);
        // The first deadline equals the later reading, so it must move on by one quantum.
        ev.arm_second = 64'd11000;
        send_event(ev);
        ev.arm_first = '1 - 64'd5;
        ev.arm_second = '0;
        send_event(ev);
        ev.arm_first = '0;
        ev.arm_second = '1;
        send_event(ev);
        ev = shaped_event(OP_TICK);
        ev.entry_mtime = deadline - 64'd1;
        send_event(ev);
        ev = shaped_event(OP_TICK);
        ev.entry_mtime = deadline + 64'd37;
        send_event(ev);
        set_config(32'd0, 32'(TICK_LIMIT_RST), 32'(TASK_COUNT_RST));
        ev = shaped_event(OP_START);
        ev.arm_first = 64'd77;
        ev.arm_second = 64'd1000;
        send_event(ev);
    endtask

    task automatic test_rotation();
        set_config(32'(QUANTUM_RST), 32'd65535, 32'd3);
        send_event(shaped_event(OP_START));
        repeat (4) send_event(shaped_event(OP_TICK));
        set_config(32'(QUANTUM_RST), 32'd65535, 32'd0);
        send_event(shaped_event(OP_TICK));
        set_config(32'(QUANTUM_RST), 32'd65535, 32'd15);
        repeat (2) send_event(shaped_event(OP_TICK));
        // Shrinking the rotation leaves the current task index beyond the new count.
        set_config(32'(QUANTUM_RST), 32'd65535, 32'd2);
        send_event(shaped_event(OP_TICK));
    endtask

    task automatic test_boot_return();
        timer_event_t ev;
        set_config(32'(QUANTUM_RST), 32'd1, 32'd4);
        send_event(shaped_event(OP_TICK));
        set_config(32'(QUANTUM_RST), 32'd0, 32'd4);
        send_event(shaped_event(OP_START));
        send_event(shaped_event(OP_TICK));
        send_event(shaped_event(OP_FINAL));
        ev = shaped_event(OP_READ);
        ev.stat_select = SEL_SWITCHES;
        send_event(ev);
    endtask

    task automatic test_random_traffic();
        logic [31:0] q_set [0:7];
        logic [31:0] lim_set [0:7];
        logic [31:0] cnt_set [0:7];
        int p, stop, run, i, pick;
        q_set   = '{32'd10000, 32'd1, 32'hFFFF_FFFF, 32'd0,
                    32'($urandom_range(1, 5000)), $urandom, 32'd500, $urandom};
        lim_set = '{32'd200, 32'd7, 32'd65535, 32'd12,
                    32'd1, 32'($urandom_range(2, 30)), 32'd0, 32'd65535};
        cnt_set = '{32'd1, 32'd8, 32'd3, 32'd0,
                    32'd15, 32'($urandom_range(1, 8)), 32'd5, 32'd8};
        for (p = 0; p < 8; p++) begin
            set_config(q_set[p], lim_set[p], cnt_set[p]);
            stop = items_sent + PHASE_ITEMS;
            while (items_sent < stop) begin
                if ($urandom_range(0, 7) != 0) send_event(shaped_event(OP_START));
                run = $urandom_range(1, 40);
                for (i = 0; i < run && items_sent < stop; i++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 8)
                        send_event(shaped_event(OP_READ));
                    else if (pick < 15)
                        send_event(noise_event());
                    else if (pick < 17)
                        send_event(shaped_event(OP_FINAL));
                    else
                        send_event(shaped_event(OP_TICK));
                end
                if ($urandom_range(0, 1) != 0) send_event(shaped_event(OP_FINAL));
                repeat ($urandom_range(1, 3)) send_event(shaped_event(OP_READ));
            end
        end
    endtask

    task automatic test_output_stall();
        int i;
        settle();
        hold_off_req = HOLD_CYCLES;
        gapless = 1'b1;
        send_event(shaped_event(OP_START));
        for (i = 0; i < 30; i++) begin
            if (i % 5 == 4)
                send_event(noise_event());
            else
                send_event(shaped_event(OP_TICK));
        end
        gapless = 1'b0;
    endtask

    initial begin : run_tests
        int k;
        for (k = 0; k < 3; k++) begin
            stat_min[k] = '1;
            stat_max[k] = '0;
            stat_sum[k] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_arming();
        test_rotation();
        test_boot_return();
        test_random_traffic();
        test_output_stall();
        settle();
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
